FILE: sv/pprl_pkg.sv
// ----------------------------------------------------------------------------
// pprl_pkg
// types and constants for the partition pair relabel block
// ----------------------------------------------------------------------------
package pprl_pkg;

   localparam int LABEL_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int INDEX_W   = 2 * LABEL_W;
   localparam int MAX_ROWS  = 64;
   localparam int GROUP_CAP = (MAX_ROWS < (1 << LABEL_W)) ? MAX_ROWS : (1 << LABEL_W);

   localparam logic [LABEL_W-1:0] FULL_LABEL = {LABEL_W{1'b1}};

   typedef struct packed {
      logic [LABEL_W-1:0] first_label;
      logic [LABEL_W-1:0] second_label;
      logic               start_new;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] combined_label;
      logic [COUNT_W-1:0] group_total;
   } rsp_type;

   typedef struct packed {
      logic               enable;
      logic [INDEX_W-1:0] index;
      logic [LABEL_W-1:0] label;
   } store_wr_type;

endpackage

FILE: sv/pprl_store.sv
// ----------------------------------------------------------------------------
// pprl_store
// pair-to-label table and label-to-pair reverse table, registered reads
// ----------------------------------------------------------------------------
module pprl_store (
   input  logic                        clock,
   input  logic                        map_rd_en,
   input  logic [pprl_pkg::INDEX_W-1:0] map_rd_addr,
   input  logic [pprl_pkg::LABEL_W-1:0] rev_rd_addr,
   input  pprl_pkg::store_wr_type      wr,
   output logic [pprl_pkg::LABEL_W-1:0] map_rd_data,
   output logic [pprl_pkg::INDEX_W-1:0] rev_rd_data
);

   logic [pprl_pkg::LABEL_W-1:0] map_mem [0:(1 << pprl_pkg::INDEX_W)-1];
   logic [pprl_pkg::INDEX_W-1:0] rev_mem [0:(1 << pprl_pkg::LABEL_W)-1];

   logic [pprl_pkg::LABEL_W-1:0] map_rd_ff;
   logic [pprl_pkg::INDEX_W-1:0] rev_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.enable) begin
         map_mem[wr.index] <= wr.label;
      end
      if (map_rd_en) begin
         map_rd_ff <= map_mem[map_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.enable) begin
         rev_mem[wr.label] <= wr.index;
      end
      rev_rd_ff <= rev_mem[rev_rd_addr];
   end

   assign map_rd_data = map_rd_ff;
   assign rev_rd_data = rev_rd_ff;

endmodule

FILE: sv/partition_pair_relabel_top.sv
// ----------------------------------------------------------------------------
// partition_pair_relabel_top
// common refinement of two partitions, one row word at a time
// ----------------------------------------------------------------------------
// rsp_strobe rises from a register after the accepted word passes ST_LOOK and
// ST_CHECK; a new word waits (busy) until ST_IDLE is back, set by the two
// dependent table reads (pair table, then reverse table) before the label decision
// reset: clears the sequencer and the group counter; no table sweep, a pair
// counts as seen only when its label is below the counter and maps back
// ----------------------------------------------------------------------------
module partition_pair_relabel_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pprl_pkg::req_type req_word,
   output logic              rsp_strobe,
   output pprl_pkg::rsp_type rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOOK  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [pprl_pkg::COUNT_W-1:0] next_ff, next_in;
   logic [pprl_pkg::INDEX_W-1:0] idx_ff;
   logic                         strobe_ff, strobe_in;
   pprl_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         accept;
   logic [pprl_pkg::INDEX_W-1:0] req_idx;
   logic [pprl_pkg::LABEL_W-1:0] map_q;
   logic [pprl_pkg::INDEX_W-1:0] rev_q;
   logic                         hit;
   pprl_pkg::store_wr_type       wr;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign req_idx = {req_word.first_label, req_word.second_label};

   pprl_store u_store (
      .clock       (clock),
      .map_rd_en   (accept),
      .map_rd_addr (req_idx),
      .rev_rd_addr (map_q),
      .wr          (wr),
      .map_rd_data (map_q),
      .rev_rd_data (rev_q)
   );

   assign hit = ({1'b0, map_q} < next_ff) && (rev_q == idx_ff);

   always_comb begin
      state_in  = state_ff;
      next_in   = next_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr.enable = 1'b0;
      wr.index  = idx_ff;
      wr.label  = next_ff[pprl_pkg::LABEL_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
               if (req_word.start_new) begin
                  next_in = '0;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            if (hit) begin
               rsp_in.combined_label = map_q;
            end else if (next_ff < pprl_pkg::COUNT_W'(pprl_pkg::GROUP_CAP)) begin
               rsp_in.combined_label = next_ff[pprl_pkg::LABEL_W-1:0];
               wr.enable             = 1'b1;
               next_in               = next_ff + 1'b1;
            end else begin
               rsp_in.combined_label = pprl_pkg::FULL_LABEL;
            end
            rsp_in.group_total = next_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         next_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         next_ff   <= next_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         idx_ff <= req_idx;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the partition pair relabel block
// ----------------------------------------------------------------------------
// a short table of rows (typed answers where they are obvious) is followed by
// random sets of rows: sets of few labels with many repeats, plain random sets,
// sets that fill the group counter to its limit and then keep going, and noisy
// runs with restarts at any row. a local model of the pair table predicts every
// answer and a monitor compares each result word, field by field, in order. the
// sender idles in bursts; results are taken as they come.
// ----------------------------------------------------------------------------
module tb_top;

   import pprl_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_WORDS = 1100;
   localparam int IDLE_LIMIT = 200;
   localparam int TAIL_CYCLES = 10;
   localparam int DIR_COUNT = 19;
   localparam int PAIR_COUNT = 1 << INDEX_W;

   typedef struct packed {
      req_type word;
      logic    typed;
      rsp_type answer;
   } stim_row;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   rsp_type             expected_q[$];
   int                  error_count = 0;
   int                  idle_cycles = 0;
   int                  burst_left = 0;
   int                  words_sent = 0;

   logic                pair_seen[PAIR_COUNT];
   logic [LABEL_W-1:0]  pair_label[PAIR_COUNT];
   logic [COUNT_W-1:0]  groups_issued;

   stim_row             dir_rows[DIR_COUNT];

   partition_pair_relabel_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // refined label of one row word, updating the local pair table
   function automatic rsp_type refine_row(input req_type w);
      logic [INDEX_W-1:0] slot;
      rsp_type            r;
      slot = {w.first_label, w.second_label};
      if (w.start_new) begin
         for (int i = 0; i < PAIR_COUNT; i++) pair_seen[i] = 1'b0;
         groups_issued = '0;
      end
      if (pair_seen[slot]) begin
         r.combined_label = pair_label[slot];
      end else if (groups_issued < GROUP_CAP) begin
         r.combined_label  = groups_issued[LABEL_W-1:0];
         pair_label[slot]  = groups_issued[LABEL_W-1:0];
         pair_seen[slot]   = 1'b1;
         groups_issued     = groups_issued + 1'b1;
      end else begin
         r.combined_label = FULL_LABEL;
      end
      r.group_total = groups_issued;
      return r;
   endfunction

   // drives one word, idling between bursts, and queues its answer on accept
   task automatic send_word(input req_type w, input logic typed, input rsp_type answer);
      rsp_type want;
      int      gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 300)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      want = refine_row(w);
      if (typed) want = answer;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      expected_q.push_back(want);
      words_sent++;
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word label %0d total %0d",
                                      rsp_word.combined_label, rsp_word.group_total));
         end else begin
            want = expected_q.pop_front();
            if (rsp_word.combined_label !== want.combined_label)
               report_mismatch($sformatf("combined_label got %0d expected %0d",
                                         rsp_word.combined_label, want.combined_label));
            if (rsp_word.group_total !== want.group_total)
               report_mismatch($sformatf("group_total got %0d expected %0d",
                                         rsp_word.group_total, want.group_total));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      req_type            w;
      req_type            used_q[$];
      int                 kind;
      int                 rows;
      int                 extra;
      int                 span;
      logic [LABEL_W-1:0] base_a;
      logic [LABEL_W-1:0] base_b;
      logic               first_row;

      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;

      for (int i = 0; i < PAIR_COUNT; i++) begin
         pair_seen[i]  = 1'b0;
         pair_label[i] = '0;
      end
      groups_issued = '0;

      // first, second, start_new | typed | combined_label, group_total
      dir_rows[0]  = {6'd0,  6'd0,  1'b0, 1'b1, 6'd0, 7'd1};  // no start after reset
      dir_rows[1]  = {6'd63, 6'd63, 1'b0, 1'b1, 6'd1, 7'd2};
      dir_rows[2]  = {6'd0,  6'd0,  1'b0, 1'b1, 6'd0, 7'd2};
      dir_rows[3]  = {6'd0,  6'd63, 1'b0, 1'b1, 6'd2, 7'd3};
      dir_rows[4]  = {6'd63, 6'd0,  1'b0, 1'b1, 6'd3, 7'd4};
      dir_rows[5]  = {6'd63, 6'd63, 1'b0, 1'b1, 6'd1, 7'd4};
      dir_rows[6]  = {6'd42, 6'd21, 1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[7]  = {6'd21, 6'd42, 1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[8]  = {6'd42, 6'd21, 1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[9]  = {6'd63, 6'd63, 1'b1, 1'b1, 6'd0, 7'd1};  // new set clears the table
      dir_rows[10] = {6'd0,  6'd0,  1'b0, 1'b1, 6'd1, 7'd2};  // old pair is new again
      dir_rows[11] = {6'd63, 6'd63, 1'b0, 1'b1, 6'd0, 7'd2};
      dir_rows[12] = {6'd63, 6'd63, 1'b1, 1'b1, 6'd0, 7'd1};
      dir_rows[13] = {6'd63, 6'd63, 1'b1, 1'b1, 6'd0, 7'd1};  // back to back new sets
      dir_rows[14] = {6'd1,  6'd2,  1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[15] = {6'd2,  6'd1,  1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[16] = {6'd32, 6'd16, 1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[17] = {6'd31, 6'd47, 1'b0, 1'b0, 6'd0, 7'd0};
      dir_rows[18] = {6'd0,  6'd0,  1'b1, 1'b1, 6'd0, 7'd1};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++)
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].answer);

      // random sets; the first one always runs into the group limit
      kind = 2;
      while (words_sent < RANDOM_WORDS) begin
         used_q.delete();
         first_row = 1'b1;
         rows  = 0;
         extra = $urandom_range(2, 30);
         span  = $urandom_range(0, 7);
         base_a = LABEL_W'($urandom_range(0, 63 - span));
         base_b = LABEL_W'($urandom_range(0, 63 - span));
         case (kind)
            0: rows = $urandom_range(1, 50);
            1: rows = $urandom_range(1, 60);
            2: rows = 1000;
            default: rows = $urandom_range(1, 20);
         endcase
         while (rows > 0) begin
            if (kind == 0) begin
               w.first_label  = LABEL_W'(base_a + $urandom_range(0, span));
               w.second_label = LABEL_W'(base_b + $urandom_range(0, span));
            end else if (used_q.size() != 0 && (kind == 2 ? groups_issued == GROUP_CAP
                                                          && $urandom_range(0, 1) == 0
                                                          : $urandom_range(0, 3) == 0)) begin
               w = used_q[$urandom_range(0, used_q.size() - 1)];
            end else begin
               w.first_label  = LABEL_W'($urandom_range(0, 63));
               w.second_label = LABEL_W'($urandom_range(0, 63));
            end
            w.start_new = first_row || (kind == 3 && $urandom_range(0, 7) == 0);
            used_q.push_back(w);
            send_word(w, 1'b0, '0);
            first_row = 1'b0;
            if (kind == 2 && groups_issued == GROUP_CAP) begin
               if (extra == 0) rows = 0;
               else extra--;
            end else begin
               rows--;
            end
         end
         kind = $urandom_range(0, 3);
      end

      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/pprl_pkg.sv
sv/pprl_store.sv
sv/partition_pair_relabel_top.sv
test/tb_top.sv
